FILE: rtl/ket_pkg.sv
`timescale 1ns / 1ps
// Package for the keyed endpoint table: slot record, write controls,
// request and status codes, sequencer states. No dependencies.
package ket_pkg;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] ENTRIES_RESET = 7'd64;

    localparam logic [1:0] MODE_UPSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    localparam logic [1:0] FAM_IPV4 = 2'd0;
    localparam logic [1:0] FAM_IPV6 = 2'd1;

    localparam logic [1:0] STATUS_SUCCESS   = 2'd0;
    localparam logic [1:0] STATUS_INVALID   = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [63:0] key;
        logic [1:0]  family;
        logic [15:0] port;
        logic [63:0] address_high;
        logic [63:0] address_low;
    } slot_t;

    typedef struct packed {
        logic data_we;
        logic valid_we;
        logic valid_bit;
    } wr_ctl_t;

endpackage

FILE: rtl/ket_slot_store.sv
`timescale 1ns / 1ps
// Slot storage: valid-bit memory and slot record memory, one read and
// one write port each, registered read data. Depends on ket_pkg.
module ket_slot_store #(
    parameter int TABLE_DEPTH = 64,
    parameter int IW = 6
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [IW-1:0]     rd_addr,
    input  logic [IW-1:0]     wr_addr,
    input  ket_pkg::wr_ctl_t  wr_ctl,
    input  ket_pkg::slot_t    wr_slot,
    output logic              rd_valid,
    output ket_pkg::slot_t    rd_slot
);
    import ket_pkg::*;

    logic  valid_mem [TABLE_DEPTH];
    slot_t slot_mem  [TABLE_DEPTH];
    logic  rd_valid_reg;
    slot_t rd_slot_reg;

    always_ff @(posedge clk)
    begin
        if (wr_ctl.valid_we)
        begin
            valid_mem[wr_addr] <= wr_ctl.valid_bit;
        end
        if (rd_en)
        begin
            rd_valid_reg <= valid_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ctl.data_we)
        begin
            slot_mem[wr_addr] <= wr_slot;
        end
        if (rd_en)
        begin
            rd_slot_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_slot  = rd_slot_reg;

endmodule

FILE: rtl/keyed_endpoint_table.sv
`timescale 1ns / 1ps
// Keyed endpoint table top level: request sequencer, slot scan, result
// register and capacity register. Depends on ket_pkg and ket_slot_store.
// A request that needs no search goes from the transfer to the finish state
// and then to the result register; others pass through the scan state first,
// which reads one slot per cycle and stops at the slot holding the key or after
// the last slot of the active capacity. One request at a time; the next is
// taken in the cycle the result shows. After reset, busy stays high while the
// valid bits are cleared. The receiver cannot stall; done marks a one-cycle result.
module keyed_endpoint_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               mode,
    input  logic [63:0]              key,
    input  logic [1:0]               family,
    input  logic [15:0]              port,
    input  logic [63:0]              address_high,
    input  logic [63:0]              address_low,
    output logic                     done,
    output logic [1:0]               status,
    output logic [1:0]               found_family,
    output logic [15:0]              found_port,
    output logic [63:0]              found_address_high,
    output logic [63:0]              found_address_low,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [ket_pkg::CFG_W-1:0] cfg_data
);
    import ket_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int MW = (CW > CFG_W) ? CW : CFG_W;

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] entries_reg;
    logic [CW-1:0]    cap;
    logic [MW-1:0]    entries_ext;

    logic [IW-1:0]    clr_idx_reg, clr_idx_next;
    logic [CW-1:0]    rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic [IW-1:0]    pidx_reg, pidx_next;
    logic             hit_reg, hit_next;
    logic [IW-1:0]    hit_idx_reg, hit_idx_next;
    slot_t            hit_slot_reg, hit_slot_next;
    logic             free_reg, free_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;

    logic [1:0]       mode_reg;
    slot_t            req_reg;
    logic             bad_reg, bad_next;

    logic             done_reg, done_next;
    logic [1:0]       status_reg, status_next;
    slot_t            found_reg, found_next;

    logic             accept;
    logic             key_ok, ep_ok, req_bad, need_scan;
    logic             match;
    logic             rd_en;
    logic [IW-1:0]    wr_addr;
    wr_ctl_t          wr_ctl;
    logic             rd_valid;
    slot_t            rd_slot;

    assign entries_ext = MW'(entries_reg);
    assign cap = (entries_ext > MW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(entries_ext);

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign key_ok = (key != 64'd0) && (key != '1);
    assign ep_ok  = (port != 16'd0) && ((family == FAM_IPV6) ||
                    ((family == FAM_IPV4) && (address_high[31:0] == 32'd0) &&
                     (address_low == 64'd0)));
    assign req_bad   = ((mode == MODE_UPSERT) && !(key_ok && ep_ok)) || (mode == MODE_RSVD);
    assign need_scan = !req_bad && key_ok && (cap != '0);

    assign match = pend_reg && rd_valid && (rd_slot.key == req_reg.key);

    ket_slot_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IW          (IW)
    ) u_store (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_idx_reg[IW-1:0]),
        .wr_addr  (wr_addr),
        .wr_ctl   (wr_ctl),
        .wr_slot  (req_reg),
        .rd_valid (rd_valid),
        .rd_slot  (rd_slot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == IW'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = need_scan ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (match || (!pend_reg && (rd_idx_reg >= cap)))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_idx_next  = clr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_slot_next = hit_slot_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        bad_next      = bad_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        found_next    = found_reg;
        rd_en         = 1'b0;
        wr_addr       = clr_idx_reg;
        wr_ctl        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_ctl.valid_we = 1'b1;
                clr_idx_next    = clr_idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_idx_next = '0;
                    hit_next    = 1'b0;
                    free_next   = 1'b0;
                    bad_next    = req_bad;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    hit_next      = 1'b1;
                    hit_idx_next  = pidx_reg;
                    hit_slot_next = rd_slot;
                end
                else if (pend_reg && !rd_valid && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = pidx_reg;
                end
                if (!match && (rd_idx_reg < cap))
                begin
                    rd_en       = 1'b1;
                    pend_next   = 1'b1;
                    pidx_next   = rd_idx_reg[IW-1:0];
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                done_next  = 1'b1;
                found_next = '0;
                wr_addr    = hit_reg ? hit_idx_reg : free_idx_reg;
                if (bad_reg)
                begin
                    status_next = STATUS_INVALID;
                end
                else if (mode_reg == MODE_UPSERT)
                begin
                    if (hit_reg || free_reg)
                    begin
                        status_next      = STATUS_SUCCESS;
                        wr_ctl.data_we   = 1'b1;
                        wr_ctl.valid_we  = 1'b1;
                        wr_ctl.valid_bit = 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_FULL;
                    end
                end
                else if (hit_reg)
                begin
                    status_next = STATUS_SUCCESS;
                    if (mode_reg == MODE_LOOKUP)
                    begin
                        found_next     = hit_slot_reg;
                        found_next.key = '0;
                    end
                    else
                    begin
                        wr_ctl.valid_we = 1'b1;
                    end
                end
                else
                begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                wr_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            entries_reg <= ENTRIES_RESET;
            clr_idx_reg <= '0;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            bad_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
            free_reg    <= free_next;
            bad_reg     <= bad_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                entries_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_slot_reg <= hit_slot_next;
        free_idx_reg <= free_idx_next;
        status_reg   <= status_next;
        found_reg    <= found_next;
        if (accept)
        begin
            mode_reg                 <= mode;
            req_reg.key              <= key;
            req_reg.family           <= family;
            req_reg.port             <= port;
            req_reg.address_high     <= address_high;
            req_reg.address_low      <= address_low;
        end
    end

    assign done               = done_reg;
    assign status             = status_reg;
    assign found_family       = found_reg.family;
    assign found_port         = found_reg.port;
    assign found_address_high = found_reg.address_high;
    assign found_address_low  = found_reg.address_low;

endmodule

FILE: rtl/ket_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the keyed endpoint table and the bind that
// attaches them. Depends on ket_pkg and keyed_endpoint_table.
module ket_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [1:0]  found_family,
    input logic [15:0] found_port,
    input logic [63:0] found_address_high,
    input logic [63:0] found_address_low
);
    import ket_pkg::*;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transfer did not raise busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_SUCCESS)) |->
        ((found_family == 2'd0) && (found_port == 16'd0) &&
         (found_address_high == 64'd0) && (found_address_low == 64'd0)))
        else $error("endpoint fields nonzero on failed request");

endmodule

bind keyed_endpoint_table ket_checker u_ket_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .done               (done),
    .status             (status),
    .found_family       (found_family),
    .found_port         (found_port),
    .found_address_high (found_address_high),
    .found_address_low  (found_address_low)
);
